// ===== rtl/segment_segment_intersection_macros.svh =====
// Assertion macros for the segment intersection block
`ifndef SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH
`define SEGMENT_SEGMENT_INTERSECTION_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off during reset
`define SSI_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off during reset
`define SSI_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/ssi_pkg.sv =====
// Shared constants for the segment intersection block
`default_nettype none
package ssi_pkg;
  localparam int COORD_BITS_DEF = 16;
  localparam int FRAC_BITS_DEF  = 8;
  localparam int OUT_BITS       = 24;
  localparam int MID_DEPTH      = 4;
  localparam int OUT_DEPTH      = 4;
endpackage
`default_nettype wire

// ===== rtl/segment_segment_intersection.sv =====
// Pipeline: 3 front stages, 1 multiply, COORD_BITS+FRAC_BITS divide stages, 2 rounding
// stages, with one queue after the front end and another after the rounding stages.
// Throughput: one segment pair per cycle while full is low; one quotient bit per stage.
// Reset: rst_ni clears all valid bits and queue pointers; both queues come up empty.
// Top level: two-segment intersection with fixed-point crossing point
`default_nettype none
`include "segment_segment_intersection_macros.svh"
module segment_segment_intersection import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         push,
  output logic                              full,
  input  wire logic signed [COORD_BITS-1:0] a_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] a_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] b_end_y_i,
  output logic                              empty,
  input  wire logic                         pop,
  output logic                              hit_o,
  output logic signed [OUT_BITS-1:0]        cross_x_o,
  output logic signed [OUT_BITS-1:0]        cross_y_o
);
  localparam int UW = 2*COORD_BITS+1;
  localparam int FW = 1 + 2*COORD_BITS + 2*(COORD_BITS+1) + 2*UW;
  localparam int RW = 1 + 2*OUT_BITS;

  logic          mid_push, mid_full, mid_pop, mid_empty;
  logic [FW-1:0] mid_wdata, mid_rdata;
  logic          res_push, res_full;
  logic [RW-1:0] res_wdata, res_rdata;

  ssi_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i, .rst_ni,
    .push_i       (push),
    .full_o       (full),
    .a_start_x_i, .a_start_y_i, .a_end_x_i, .a_end_y_i,
    .b_start_x_i, .b_start_y_i, .b_end_x_i, .b_end_y_i,
    .item_valid_o (mid_push),
    .item_data_o  (mid_wdata),
    .item_full_i  (mid_full)
  );

  ssi_fifo #(.W(FW), .DEPTH(MID_DEPTH)) u_mid_q (
    .clk_i, .rst_ni,
    .push_i  (mid_push),
    .wdata_i (mid_wdata),
    .pop_i   (mid_pop),
    .rdata_o (mid_rdata),
    .full_o  (mid_full),
    .empty_o (mid_empty)
  );

  ssi_back #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i, .rst_ni,
    .item_empty_i (mid_empty),
    .item_data_i  (mid_rdata),
    .item_pop_o   (mid_pop),
    .res_push_o   (res_push),
    .res_data_o   (res_wdata),
    .res_full_i   (res_full)
  );

  ssi_fifo #(.W(RW), .DEPTH(OUT_DEPTH)) u_res_q (
    .clk_i, .rst_ni,
    .push_i  (res_push),
    .wdata_i (res_wdata),
    .pop_i   (pop),
    .rdata_o (res_rdata),
    .full_o  (res_full),
    .empty_o (empty)
  );

  assign {hit_o, cross_x_o, cross_y_o} = res_rdata;

  `SSI_ASSERT_IMPL(a_miss_zero, !empty && !hit_o, {cross_x_o, cross_y_o} == '0, "nonzero miss")
  `SSI_ASSERT_IMPL(a_mid_no_overflow, mid_push, !mid_full, "push into full middle queue")
  `SSI_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "push into full result queue")
  `SSI_ASSERT_NEXT(a_res_hold, !empty && !pop, !empty, "waiting result dropped")
endmodule
`default_nettype wire

// ===== rtl/ssi_fifo.sv =====
// Small first-word-fall-through queue
`default_nettype none
module ssi_fifo import ssi_pkg::*; #(
  parameter int W     = 8,
  parameter int DEPTH = MID_DEPTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         push_i,
  input  wire logic [W-1:0] wdata_i,
  input  wire logic         pop_i,
  output logic     [W-1:0]  rdata_o,
  output logic              full_o,
  output logic              empty_o
);
  localparam int AW = $clog2(DEPTH);

  logic [W-1:0] mem_q [DEPTH];
  logic [AW-1:0] wptr_q, rptr_q;
  logic [AW:0]   cnt_q;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= wptr_q + 1'b1;
      if (do_pop)  rptr_q <= rptr_q + 1'b1;
      if (do_push && !do_pop) cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wptr_q] <= wdata_i;
  end
endmodule
`default_nettype wire

// ===== rtl/ssi_front.sv =====
// Front end: differences, cross products and hit classification
`default_nettype none
module ssi_front import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int UW = 2*C+1,
  localparam int FW = 1 + 2*C + 2*(C+1) + 2*UW
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                push_i,
  output logic                     full_o,
  input  wire logic signed [C-1:0] a_start_x_i,
  input  wire logic signed [C-1:0] a_start_y_i,
  input  wire logic signed [C-1:0] a_end_x_i,
  input  wire logic signed [C-1:0] a_end_y_i,
  input  wire logic signed [C-1:0] b_start_x_i,
  input  wire logic signed [C-1:0] b_start_y_i,
  input  wire logic signed [C-1:0] b_end_x_i,
  input  wire logic signed [C-1:0] b_end_y_i,
  output logic                     item_valid_o,
  output logic [FW-1:0]            item_data_o,
  input  wire logic                item_full_i
);
  localparam int DW = C+1;
  localparam int PW = 2*C+2;

  logic [2:0] vld_q;
  logic       en;

  logic signed [C-1:0]  ax1_q, ay1_q;
  logic signed [DW-1:0] dax1_q, day1_q, dbx1_q, dby1_q, dx1_q, dy1_q;

  logic signed [C-1:0]  ax2_q, ay2_q;
  logic signed [DW-1:0] dax2_q, day2_q;
  logic signed [PW-1:0] pd0_q, pd1_q, pt0_q, pt1_q, ps0_q, ps1_q;

  logic signed [PW-1:0] den, tn, sn, den_a, tn_n, sn_n;
  logic                 hit_d;
  logic [FW-1:0]        item_d, item_q;

  // hold every stage while the last one cannot hand off
  assign en           = !(vld_q[2] && item_full_i);
  assign full_o       = !en;
  assign item_valid_o = vld_q[2] && !item_full_i;
  assign item_data_o  = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[1:0], push_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax1_q  <= a_start_x_i;
      ay1_q  <= a_start_y_i;
      dax1_q <= DW'(a_end_x_i) - DW'(a_start_x_i);
      day1_q <= DW'(a_end_y_i) - DW'(a_start_y_i);
      dbx1_q <= DW'(b_end_x_i) - DW'(b_start_x_i);
      dby1_q <= DW'(b_end_y_i) - DW'(b_start_y_i);
      dx1_q  <= DW'(a_start_x_i) - DW'(b_start_x_i);
      dy1_q  <= DW'(a_start_y_i) - DW'(b_start_y_i);

      ax2_q  <= ax1_q;
      ay2_q  <= ay1_q;
      dax2_q <= dax1_q;
      day2_q <= day1_q;
      pd0_q  <= PW'(dax1_q * dby1_q);
      pd1_q  <= PW'(day1_q * dbx1_q);
      pt0_q  <= PW'(dbx1_q * dy1_q);
      pt1_q  <= PW'(dby1_q * dx1_q);
      ps0_q  <= PW'(dax1_q * dy1_q);
      ps1_q  <= PW'(day1_q * dx1_q);

      item_q <= item_d;
    end
  end

  always_comb begin
    den = pd0_q - pd1_q;
    tn  = pt0_q - pt1_q;
    sn  = ps0_q - ps1_q;
    // fold the sign of den into the numerators
    den_a = den[PW-1] ? -den : den;
    tn_n  = den[PW-1] ? -tn  : tn;
    sn_n  = den[PW-1] ? -sn  : sn;
    hit_d = (den != '0) && !tn_n[PW-1] && (tn_n <= den_a)
            && !sn_n[PW-1] && (sn_n <= den_a);
    item_d = {hit_d, ax2_q, ay2_q, dax2_q, day2_q, tn_n[UW-1:0], den_a[UW-1:0]};
  end
endmodule
`default_nettype wire

// ===== rtl/ssi_back.sv =====
// Back end: pipelined division and rounding of the crossing point
`default_nettype none
module ssi_back import ssi_pkg::*; #(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF,
  localparam int C  = COORD_BITS,
  localparam int F  = FRAC_BITS,
  localparam int UW = 2*C+1,
  localparam int FW = 1 + 2*C + 2*(C+1) + 2*UW,
  localparam int RW = 1 + 2*OUT_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          item_empty_i,
  input  wire logic [FW-1:0] item_data_i,
  output logic               item_pop_o,
  output logic               res_push_o,
  output logic [RW-1:0]      res_data_o,
  input  wire logic          res_full_i
);
  localparam int DW  = C+1;
  localparam int QB  = C+F;
  localparam int NS  = QB+1;
  localparam int NW  = C+UW+F;
  localparam int SBW = 1 + 2*C + 2 + UW;
  localparam int EW  = (C+F+3 > OUT_BITS) ? C+F+3 : OUT_BITS;
  localparam logic signed [EW-1:0] SAT_HI = EW'((64'sd1 <<< (OUT_BITS-1)) - 64'sd1);
  localparam logic signed [EW-1:0] SAT_LO = -SAT_HI - EW'(1);

  logic en;
  logic [NS+1:0] vld_q;

  logic [UW-1:0]  rx_q [NS];
  logic [UW-1:0]  ry_q [NS];
  logic [QB-1:0]  lx_q [NS];
  logic [QB-1:0]  ly_q [NS];
  logic [SBW-1:0] sb_q [NS];
  logic [UW-1:0]  rx_d [NS];
  logic [UW-1:0]  ry_d [NS];
  logic [QB-1:0]  lx_d [NS];
  logic [QB-1:0]  ly_d [NS];
  logic [SBW-1:0] sb_d [NS];

  // unpacked front transaction
  logic                 in_hit;
  logic signed [C-1:0]  in_ax, in_ay;
  logic signed [DW-1:0] in_dax, in_day;
  logic [UW-1:0]        in_tn, in_den;
  logic [DW-1:0]        mag_x, mag_y;
  logic [NW-1:0]        nx, ny;

  // rounding stage A
  logic signed [EW-1:0] flx_d, fly_d, flx_q, fly_q;
  logic [UW-1:0]        frx_d, fry_d, frx_q, fry_q, dena_q;
  logic                 hita_q;

  // rounding stage B
  logic [RW-1:0] res_d, res_q;

  assign en         = !(vld_q[NS+1] && res_full_i);
  assign item_pop_o = en && !item_empty_i;
  assign res_push_o = vld_q[NS+1] && !res_full_i;
  assign res_data_o = res_q;

  assign {in_hit, in_ax, in_ay, in_dax, in_day, in_tn, in_den} = item_data_i;
  assign mag_x = in_dax[DW-1] ? -in_dax : in_dax;
  assign mag_y = in_day[DW-1] ? -in_day : in_day;
  assign nx    = NW'(mag_x[C-1:0] * in_tn) << F;
  assign ny    = NW'(mag_y[C-1:0] * in_tn) << F;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS:0], item_pop_o};
    end
  end

  always_comb begin
    logic [UW:0] tx, ty, dd;
    logic        gx, gy;
    rx_d[0] = nx[NW-1:QB];
    ry_d[0] = ny[NW-1:QB];
    lx_d[0] = nx[QB-1:0];
    ly_d[0] = ny[QB-1:0];
    sb_d[0] = {in_hit, in_ax, in_ay, in_dax[DW-1], in_day[DW-1], in_den};
    for (int k = 1; k < NS; k++) begin
      // one restoring quotient bit per stage on each axis
      dd = {1'b0, sb_q[k-1][UW-1:0]};
      tx = {rx_q[k-1], lx_q[k-1][QB-1]};
      ty = {ry_q[k-1], ly_q[k-1][QB-1]};
      gx = (tx >= dd);
      gy = (ty >= dd);
      rx_d[k] = gx ? UW'(tx - dd) : tx[UW-1:0];
      ry_d[k] = gy ? UW'(ty - dd) : ty[UW-1:0];
      lx_d[k] = {lx_q[k-1][QB-2:0], gx};
      ly_d[k] = {ly_q[k-1][QB-2:0], gy};
      sb_d[k] = sb_q[k-1];
    end
  end

  always_comb begin
    logic                 hit_l, nx_l, ny_l;
    logic signed [C-1:0]  ax_l, ay_l;
    logic [UW-1:0]        den_l;
    logic signed [EW-1:0] bx, by, qx, qy;
    {hit_l, ax_l, ay_l, nx_l, ny_l, den_l} = sb_q[QB];
    bx = EW'(ax_l) <<< F;
    by = EW'(ay_l) <<< F;
    qx = EW'(lx_q[QB]);
    qy = EW'(ly_q[QB]);
    // negative direction: floor of the negated quotient, remainder flipped
    flx_d = nx_l ? bx - qx - EW'(rx_q[QB] != '0) : bx + qx;
    fly_d = ny_l ? by - qy - EW'(ry_q[QB] != '0) : by + qy;
    frx_d = (nx_l && rx_q[QB] != '0) ? den_l - rx_q[QB] : rx_q[QB];
    fry_d = (ny_l && ry_q[QB] != '0) ? den_l - ry_q[QB] : ry_q[QB];
  end

  always_comb begin
    logic [UW:0]          tx2, ty2, dd2;
    logic                 ux, uy;
    logic signed [EW-1:0] fx, fy;
    dd2 = {1'b0, dena_q};
    tx2 = {frx_q, 1'b0};
    ty2 = {fry_q, 1'b0};
    // round half away from zero
    ux  = (tx2 > dd2) || (tx2 == dd2 && !flx_q[EW-1]);
    uy  = (ty2 > dd2) || (ty2 == dd2 && !fly_q[EW-1]);
    fx  = flx_q + EW'(ux);
    fy  = fly_q + EW'(uy);
    if (fx > SAT_HI) fx = SAT_HI;
    if (fx < SAT_LO) fx = SAT_LO;
    if (fy > SAT_HI) fy = SAT_HI;
    if (fy < SAT_LO) fy = SAT_LO;
    if (hita_q) res_d = {1'b1, fx[OUT_BITS-1:0], fy[OUT_BITS-1:0]};
    else        res_d = '0;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < NS; k++) begin
        rx_q[k] <= rx_d[k];
        ry_q[k] <= ry_d[k];
        lx_q[k] <= lx_d[k];
        ly_q[k] <= ly_d[k];
        sb_q[k] <= sb_d[k];
      end
      flx_q  <= flx_d;
      fly_q  <= fly_d;
      frx_q  <= frx_d;
      fry_q  <= fry_d;
      dena_q <= sb_q[QB][UW-1:0];
      hita_q <= sb_q[QB][SBW-1];
      res_q  <= res_d;
    end
  end
endmodule
`default_nettype wire
